// ----- rtl/core/vfc_pkg.sv -----
package vfc_pkg;

  localparam int SIZE_X = 64;
  localparam int SIZE_Y = 32;
  localparam int SIZE_Z = 64;

  localparam int XW = $clog2(SIZE_X);
  localparam int YW = $clog2(SIZE_Y);
  localparam int ZW = $clog2(SIZE_Z);
  localparam int AW = XW + YW + ZW;
  localparam int DEPTH = 1 << AW;
  localparam int TW = 3;

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_MESH   = 2'd1;
  localparam logic [1:0] REQ_HEIGHT = 2'd2;

  localparam logic [TW-1:0] BT_VOID  = 3'd0;
  localparam logic [TW-1:0] BT_DIRT  = 3'd1;
  localparam logic [TW-1:0] BT_GRASS = 3'd2;
  localparam logic [TW-1:0] BT_LEAF  = 3'd3;
  localparam logic [TW-1:0] BT_LOG   = 3'd4;

  localparam logic [2:0] SIDE_SOUTH  = 3'd0;
  localparam logic [2:0] SIDE_EAST   = 3'd1;
  localparam logic [2:0] SIDE_NORTH  = 3'd2;
  localparam logic [2:0] SIDE_WEST   = 3'd3;
  localparam logic [2:0] SIDE_TOP    = 3'd4;
  localparam logic [2:0] SIDE_BOTTOM = 3'd5;

  localparam logic [2:0] COL_BLACK   = 3'd0;
  localparam logic [2:0] COL_BROWN   = 3'd1;
  localparam logic [2:0] COL_GREEN   = 3'd2;
  localparam logic [2:0] COL_DKGREEN = 3'd3;
  localparam logic [2:0] COL_DKBROWN = 3'd4;

  // probe steps: the voxel itself, then the six sides in output order
  localparam logic [2:0] STEP_CENTER = 3'd0;
  localparam logic [2:0] STEP_SOUTH  = 3'd1;
  localparam logic [2:0] STEP_EAST   = 3'd2;
  localparam logic [2:0] STEP_NORTH  = 3'd3;
  localparam logic [2:0] STEP_WEST   = 3'd4;
  localparam logic [2:0] STEP_TOP    = 3'd5;
  localparam logic [2:0] STEP_BOTTOM = 3'd6;
  localparam logic [2:0] STEP_END    = 3'd7;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [TW-1:0] wdata;
    logic [AW-1:0] raddr;
  } vfc_mem_req_t;

  function automatic logic signed [1:0] step_dx(input logic [2:0] step);
    case (step)
      STEP_EAST: return 2'sd1;
      STEP_WEST: return -2'sd1;
      default:   return 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] step_dy(input logic [2:0] step);
    case (step)
      STEP_TOP:    return 2'sd1;
      STEP_BOTTOM: return -2'sd1;
      default:     return 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] step_dz(input logic [2:0] step);
    case (step)
      STEP_SOUTH: return -2'sd1;
      STEP_NORTH: return 2'sd1;
      default:    return 2'sd0;
    endcase
  endfunction

  function automatic logic [2:0] face_colour(input logic [TW-1:0] t, input logic [2:0] side);
    case (t)
      BT_DIRT:  return COL_BROWN;
      BT_GRASS: return (side == SIDE_TOP) ? COL_GREEN : COL_BROWN;
      BT_LEAF:  return COL_DKGREEN;
      BT_LOG:   return COL_DKBROWN;
      default:  return COL_BLACK;
    endcase
  endfunction

endpackage

// ----- rtl/core/vfc_ifs.sv -----
interface vfc_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic signed [7:0] pos_x;
  logic signed [7:0] pos_y;
  logic signed [7:0] pos_z;
  logic [2:0]        block_type;

  modport source(output valid, req_type, pos_x, pos_y, pos_z, block_type, input ready);
  modport sink(input valid, req_type, pos_x, pos_y, pos_z, block_type, output ready);
endinterface

interface vfc_rsp_if;
  logic              valid;
  logic              ready;
  logic              face_valid;
  logic [2:0]        face_side;
  logic [2:0]        face_color;
  logic signed [6:0] column_height;
  logic              last;

  modport source(output valid, face_valid, face_side, face_color, column_height, last,
                 input ready);
  modport sink(input valid, face_valid, face_side, face_color, column_height, last,
               output ready);
endinterface

// ----- rtl/core/vfc_mem.sv -----
module vfc_mem import vfc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  vfc_mem_req_t  mreq,
  output logic [TW-1:0] rdata,
  output logic          busy
);

  logic [TW-1:0] store [DEPTH];
  logic [AW-1:0] clr_addr;

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (&clr_addr) begin
        busy <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst && busy) begin
      store[clr_addr] <= BT_VOID;
    end else if (!rst && mreq.we) begin
      store[mreq.waddr] <= mreq.wdata;
    end
    rdata <= store[mreq.raddr];
  end

endmodule

// ----- rtl/core/vfc_ctrl.sv -----
module vfc_ctrl import vfc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  vfc_req_if.sink           req,
  vfc_rsp_if.source         rsp,
  input  logic              busy,
  input  logic [TW-1:0]     rdata,
  output vfc_mem_req_t      mreq
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_WRITE  = 5'b00010,
    S_MESH   = 5'b00100,
    S_HEIGHT = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t            state;
  logic [1:0]        kind;
  logic signed [7:0] bx, by, bz;
  logic [TW-1:0]     btype;
  logic [TW-1:0]     ctype;
  logic [2:0]        step;
  logic [2:0]        step_d;
  logic [YW-1:0]     hy;
  logic [YW-1:0]     hy_d;
  logic              ydone;
  logic              vld_d;
  logic              oob_d;
  logic [5:0]        mask;
  logic signed [6:0] hres;

  logic              ovalid;
  logic              oface;
  logic [2:0]        oside;
  logic [2:0]        ocolor;
  logic signed [6:0] oheight;
  logic              olast;

  logic signed [1:0] dx, dy, dz;
  logic signed [8:0] px, py, pz;
  logic              inb;
  logic [AW-1:0]     paddr;
  logic [2:0]        sel;
  logic [5:0]        oneh;
  logic              take;

  assign take = req.valid && req.ready;
  assign req.ready = (state == S_IDLE) && !busy;

  // shared probe unit: coordinate offset, bounds check, address
  always_comb begin
    dx = (state == S_HEIGHT) ? 2'sd0 : step_dx(step);
    dy = (state == S_HEIGHT) ? 2'sd0 : step_dy(step);
    dz = (state == S_HEIGHT) ? 2'sd0 : step_dz(step);
    px = {bx[7], bx} + {{7{dx[1]}}, dx};
    pz = {bz[7], bz} + {{7{dz[1]}}, dz};
    if (state == S_HEIGHT) begin
      py = $signed(9'(hy));
    end else begin
      py = {by[7], by} + {{7{dy[1]}}, dy};
    end
    inb = !px[8] && (px[7:0] < 8'(SIZE_X)) &&
          !py[8] && (py[7:0] < 8'(SIZE_Y)) &&
          !pz[8] && (pz[7:0] < 8'(SIZE_Z));
    paddr = {pz[ZW-1:0], py[YW-1:0], px[XW-1:0]};
  end

  always_comb begin
    mreq.we    = (state == S_WRITE) && inb;
    mreq.waddr = paddr;
    mreq.wdata = btype;
    mreq.raddr = paddr;
  end

  always_comb begin
    sel = SIDE_SOUTH;
    for (int i = 5; i >= 0; i--) begin
      if (mask[i]) begin
        sel = 3'(i);
      end
    end
    oneh = 6'(1) << sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      if (rsp.ready && state != S_EMIT) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            kind  <= req.req_type;
            bx    <= req.pos_x;
            by    <= req.pos_y;
            bz    <= req.pos_z;
            btype <= req.block_type;
            step  <= STEP_CENTER;
            hy    <= YW'(SIZE_Y - 1);
            ydone <= 1'b0;
            vld_d <= 1'b0;
            mask  <= '0;
            case (req.req_type)
              REQ_WRITE:  state <= S_WRITE;
              REQ_MESH:   state <= S_MESH;
              REQ_HEIGHT: state <= S_HEIGHT;
              default:    state <= S_IDLE;
            endcase
          end
        end
        S_WRITE: begin
          state <= S_IDLE;
        end
        S_MESH: begin
          if (step != STEP_END) begin
            vld_d  <= 1'b1;
            step_d <= step;
            oob_d  <= !inb;
            step   <= step + 3'd1;
          end else begin
            vld_d <= 1'b0;
          end
          if (vld_d) begin
            if (step_d == STEP_CENTER) begin
              if (oob_d || rdata == BT_VOID) begin
                mask  <= '0;
                state <= S_EMIT;
              end else begin
                ctype <= rdata;
              end
            end else begin
              mask <= mask | (6'(!oob_d && rdata == BT_VOID) << (step_d - STEP_SOUTH));
              if (step_d == STEP_BOTTOM) begin
                state <= S_EMIT;
              end
            end
          end
        end
        S_HEIGHT: begin
          if (!ydone) begin
            vld_d <= 1'b1;
            hy_d  <= hy;
            oob_d <= !inb;
            if (hy == '0) begin
              ydone <= 1'b1;
            end else begin
              hy <= hy - 1'b1;
            end
          end else begin
            vld_d <= 1'b0;
          end
          if (vld_d) begin
            if (oob_d || rdata != BT_VOID) begin
              hres  <= $signed(7'(hy_d));
              state <= S_EMIT;
            end else if (hy_d == '0) begin
              hres  <= -7'sd1;
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (!ovalid || rsp.ready) begin
            ovalid <= 1'b1;
            if (kind == REQ_HEIGHT) begin
              oface   <= 1'b0;
              oside   <= SIDE_SOUTH;
              ocolor  <= COL_BLACK;
              oheight <= hres;
              olast   <= 1'b1;
              state   <= S_IDLE;
            end else if (mask == '0) begin
              oface   <= 1'b0;
              oside   <= SIDE_SOUTH;
              ocolor  <= COL_BLACK;
              oheight <= '0;
              olast   <= 1'b1;
              state   <= S_IDLE;
            end else begin
              oface   <= 1'b1;
              oside   <= sel;
              ocolor  <= face_colour(ctype, sel);
              oheight <= '0;
              olast   <= (mask & ~oneh) == '0;
              mask    <= mask & ~oneh;
              if ((mask & ~oneh) == '0) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid         = ovalid;
  assign rsp.face_valid    = oface;
  assign rsp.face_side     = oside;
  assign rsp.face_color    = ocolor;
  assign rsp.column_height = oheight;
  assign rsp.last          = olast;

endmodule

// ----- rtl/core/voxel_face_culling.sv -----
// voxel face culling: a voxel store of block types with write, mesh and
// column height requests
// req channel: one transaction per request (req_type, pos_x/y/z, block_type);
// a write produces no result, mesh and height requests produce result records
// rsp channel: result records; last marks the final record of a request
// a mesh query on a non-void voxel yields one record per in-bounds void
// neighbor in the order south, east, north, west, top, bottom, or a single
// invalid record when there are none or the voxel is void or out of bounds
// a height query yields one record with the highest non-void y, -1 if none,
// or SIZE_Y - 1 for a column outside the store; the store's single read port
// takes one probe per cycle through the shared address and bounds unit
// a new request is taken once the previous one has loaded its last record
// into the output register, which may still wait for the receiver
// a stalled receiver holds the output register and the sequencer waits
// reset: synchronous; afterwards the store is swept to void, one entry per
// cycle over 2^(XW+YW+ZW) = 131072 entries, and req.ready stays low meanwhile
module voxel_face_culling import vfc_pkg::*; (
  input logic       clk,
  input logic       rst,
  vfc_req_if.sink   req,
  vfc_rsp_if.source rsp
);

  vfc_mem_req_t  mreq;
  logic [TW-1:0] rdata;
  logic          busy;

  vfc_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .mreq  (mreq),
    .rdata (rdata),
    .busy  (busy)
  );

  vfc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .busy  (busy),
    .rdata (rdata),
    .mreq  (mreq)
  );

`ifndef SYNTHESIS
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    busy |-> !req.ready)
    else $error("request taken during clearing sweep");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready &&
     (req.req_type == REQ_WRITE || req.req_type == REQ_MESH ||
      req.req_type == REQ_HEIGHT)) |=> !req.ready)
    else $error("request taken while previous one in progress");

  a_invalid_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.face_valid) |-> rsp.last)
    else $error("invalid or height record not marked last");

  a_face_no_height: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.face_valid) |-> (rsp.column_height == 7'sd0))
    else $error("face record carries a height");
`endif

endmodule
